/* sv/fru_led_pkg.sv */
// ----------------------------------------------------------------------------
// fru_led_pkg
// Shared types, codes and constants of the front-panel LED controller.
// ----------------------------------------------------------------------------
package fru_led_pkg;

   localparam int NUM_LEDS_DEFAULT = 3;
   localparam int LED_ID_W         = 3;
   localparam int MASK_W           = 3;

   // request operations
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_SET   = 2'd1;
   localparam logic [1:0] OP_LOCAL = 2'd2;
   localparam logic [1:0] OP_READ  = 2'd3;

   // response status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_BAD_LED = 2'd1;
   localparam logic [1:0] STATUS_BAD_FN  = 2'd2;

   // LED function codes
   localparam logic [7:0] FN_OFF       = 8'h00;
   localparam logic [7:0] FN_BLINK_MAX = 8'hFA;
   localparam logic [7:0] FN_RESTORE   = 8'hFC;
   localparam logic [7:0] FN_ON        = 8'hFF;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_TICK,
      ST_APPLY,
      ST_REPLY
   } state_type;

   typedef struct packed {
      logic [1:0]          op;
      logic [LED_ID_W-1:0] led_id;
      logic [7:0]          led_function;
      logic [7:0]          on_time;
      logic                local_on;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic              override_active;
      logic              local_value;
      logic [7:0]        override_function;
      logic [7:0]        override_on_time;
      logic [MASK_W-1:0] lit_mask;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic                capture;  // latch the request
      logic                tick;     // step the LED at count
      logic                apply;    // execute the latched request
      logic [LED_ID_W-1:0] count;    // LED visited by the tick sweep
   } cmd_type;

endpackage

/* sv/fru_led_ctrl.sv */
// ----------------------------------------------------------------------------
// fru_led_ctrl
// Sequencer: takes a request, sweeps the LEDs (tick) or executes it, replies.
// ----------------------------------------------------------------------------
module fru_led_ctrl #(
   parameter int NUM_LEDS = fru_led_pkg::NUM_LEDS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [1:0]           req_op,
   output logic                 busy,
   output logic                 rsp_strobe,
   output fru_led_pkg::cmd_type cmd
);

   localparam int IDX_W = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_LEDS - 1);

   fru_led_pkg::state_type state_ff, state_in;
   logic [IDX_W-1:0]       count_ff, count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fru_led_pkg::ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      case (state_ff)
         fru_led_pkg::ST_IDLE: begin
            count_in = '0;
            if (start) begin
               if (req_op == fru_led_pkg::OP_TICK) begin
                  state_in = fru_led_pkg::ST_TICK;
               end else begin
                  state_in = fru_led_pkg::ST_APPLY;
               end
            end
         end
         fru_led_pkg::ST_TICK: begin
            if (count_ff == LAST_IDX) begin
               state_in = fru_led_pkg::ST_REPLY;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
         fru_led_pkg::ST_APPLY: state_in = fru_led_pkg::ST_REPLY;
         fru_led_pkg::ST_REPLY: state_in = fru_led_pkg::ST_IDLE;
         default:               state_in = fru_led_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      busy        = 1'b1;
      rsp_strobe  = 1'b0;
      cmd.capture = 1'b0;
      cmd.tick    = 1'b0;
      cmd.apply   = 1'b0;
      cmd.count   = fru_led_pkg::LED_ID_W'(count_ff);
      case (state_ff)
         fru_led_pkg::ST_IDLE: begin
            busy        = 1'b0;
            cmd.capture = start;
         end
         fru_led_pkg::ST_TICK:  cmd.tick   = 1'b1;
         fru_led_pkg::ST_APPLY: cmd.apply  = 1'b1;
         fru_led_pkg::ST_REPLY: rsp_strobe = 1'b1;
         default:               busy       = 1'b1;
      endcase
   end

endmodule

/* sv/fru_led_dp.sv */
// ----------------------------------------------------------------------------
// fru_led_dp
// Per-LED records, blink update, request execution and reply formatting.
// ----------------------------------------------------------------------------
module fru_led_dp #(
   parameter int NUM_LEDS = fru_led_pkg::NUM_LEDS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  fru_led_pkg::cmd_type cmd,
   input  fru_led_pkg::req_type req_data,
   output logic [1:0]           req_op,
   output fru_led_pkg::rsp_type rsp_data
);

   localparam int IDX_W = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;

   typedef struct packed {
      logic       pin_lit;
      logic       override_flag;
      logic       override_level;
      logic       local_level;
      logic [7:0] countdown;
      logic [7:0] off_time;
      logic [7:0] on_period;
   } led_entry_type;

   // LED 0 comes up lit under local control, the others dark
   localparam led_entry_type ENTRY_RST_FIRST = '{
      pin_lit:        1'b1,
      override_flag:  1'b0,
      override_level: 1'b0,
      local_level:    1'b1,
      countdown:      8'd0,
      off_time:       fru_led_pkg::FN_ON,
      on_period:      8'd0
   };
   localparam led_entry_type ENTRY_RST_OTHER = '0;

   led_entry_type                  entry_ff [NUM_LEDS];
   led_entry_type                  cur, upd;
   fru_led_pkg::req_type           req_ff;
   logic [1:0]                     status_ff, status_in;
   logic [IDX_W-1:0]               cur_idx;
   logic                           id_valid;
   logic                           write_en;
   logic [7:0]                     dec;
   logic [7:0]                     fn;
   logic [fru_led_pkg::MASK_W-1:0] lit_mask;

   assign req_op   = req_data.op;
   assign id_valid = ({1'b0, req_ff.led_id} < 4'(NUM_LEDS));
   assign cur_idx  = cmd.tick ? cmd.count[IDX_W-1:0] : req_ff.led_id[IDX_W-1:0];
   assign fn       = req_ff.led_function;

   always_comb begin
      cur = '0;
      if (cmd.tick || id_valid) begin
         cur = entry_ff[cur_idx];
      end
   end

   assign dec = cur.countdown - 8'd1;

   always_comb begin
      upd       = cur;
      status_in = status_ff;
      write_en  = 1'b0;
      if (cmd.tick) begin
         write_en = 1'b1;
         if (cur.override_flag) begin
            if (cur.off_time == fru_led_pkg::FN_OFF || cur.off_time == fru_led_pkg::FN_ON) begin
               // steady override: drive once the countdown runs out
               upd.countdown = dec;
               if (cur.countdown == 8'd0) begin
                  upd.pin_lit        = (cur.off_time == fru_led_pkg::FN_ON);
                  upd.override_level = (cur.off_time == fru_led_pkg::FN_ON);
               end
            end else if (dec == 8'd0) begin
               // end of phase: toggle and reload with the new phase
               upd.pin_lit        = ~cur.override_level;
               upd.override_level = ~cur.override_level;
               upd.countdown      = cur.override_level ? cur.off_time : cur.on_period;
            end else begin
               upd.countdown = dec;
            end
         end
      end else if (cmd.apply) begin
         if (!id_valid) begin
            status_in = fru_led_pkg::STATUS_BAD_LED;
         end else begin
            write_en  = 1'b1;
            status_in = fru_led_pkg::STATUS_OK;
            case (req_ff.op)
               fru_led_pkg::OP_SET: begin
                  if (fn != fru_led_pkg::FN_OFF && fn <= fru_led_pkg::FN_BLINK_MAX) begin
                     upd.off_time       = fn;
                     upd.on_period      = req_ff.on_time;
                     upd.override_flag  = 1'b1;
                     upd.pin_lit        = ~cur.override_level;
                     upd.override_level = ~cur.override_level;
                     upd.countdown      = cur.override_level ? fn : req_ff.on_time;
                  end else if (fn == fru_led_pkg::FN_OFF || fn == fru_led_pkg::FN_ON) begin
                     // leave override without driving the pin
                     upd.off_time      = fn;
                     upd.on_period     = 8'd0;
                     upd.override_flag = 1'b0;
                  end else if (fn == fru_led_pkg::FN_RESTORE) begin
                     upd.override_flag = 1'b0;
                     upd.pin_lit       = cur.local_level;
                  end else begin
                     status_in = fru_led_pkg::STATUS_BAD_FN;
                  end
               end
               fru_led_pkg::OP_LOCAL: begin
                  if (!cur.override_flag) begin
                     upd.local_level = req_ff.local_on;
                     upd.pin_lit     = req_ff.local_on;
                  end
               end
               default: upd = cur;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_LEDS; i++) begin
            entry_ff[i] <= (i == 0) ? ENTRY_RST_FIRST : ENTRY_RST_OTHER;
         end
      end else if (write_en) begin
         entry_ff[cur_idx] <= upd;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff    <= req_data;
         status_ff <= fru_led_pkg::STATUS_OK;
      end else begin
         status_ff <= status_in;
      end
   end

   // reply: selected LED as it stands, zeros when out of range
   always_comb begin
      rsp_data.status            = status_ff;
      rsp_data.override_active   = id_valid & cur.override_flag;
      rsp_data.local_value       = id_valid & cur.local_level;
      rsp_data.override_function = id_valid ? cur.off_time : 8'd0;
      rsp_data.override_on_time  = id_valid ? cur.on_period : 8'd0;
      rsp_data.lit_mask          = lit_mask;
   end

   for (genvar n = 0; n < fru_led_pkg::MASK_W; n++) begin : g_mask
      if (n < NUM_LEDS) begin : g_led
         assign lit_mask[n] = entry_ff[n].pin_lit;
      end else begin : g_none
         assign lit_mask[n] = 1'b0;
      end
   end

endmodule

/* sv/fru_led_blink_controller.sv */
// ----------------------------------------------------------------------------
// fru_led_blink_controller
// Front-panel LED controller with local and override (blink) control.
// ----------------------------------------------------------------------------
// Usage:
//   Requests (tick, set function, local drive, read state) enter on req_data
//   and transfer at the rising edge where start is high and busy is low.
//   busy stays high until the reply has been shown, so one request is in
//   work at a time.
//   Each request yields one reply on rsp_data, valid for exactly one cycle
//   while rsp_strobe is high. The receiver cannot stall the block; it must
//   take the reply in that cycle.
//   A set, local drive or read passes through an execute step, then the
//   reply step.
//   A tick walks the LED records one per cycle through a single shared
//   update path, then gives its reply.
//   busy drops in the idle state after each reply, so the block takes no
//   new request before it is through with the last one.
//   Reset: synchronous, active high. LED 0 comes up lit under local control
//   with local level one; all other LEDs come up dark under local control.
// ----------------------------------------------------------------------------
module fru_led_blink_controller #(
   parameter int NUM_LEDS = fru_led_pkg::NUM_LEDS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  fru_led_pkg::req_type req_data,
   output logic                 rsp_strobe,
   output fru_led_pkg::rsp_type rsp_data
);

   fru_led_pkg::cmd_type cmd;
   logic [1:0]           req_op;

   // sequencer: capture, tick sweep, execute, reply
   fru_led_ctrl #(
      .NUM_LEDS (NUM_LEDS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_op     (req_op),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd)
   );

   // LED records and their update logic
   fru_led_dp #(
      .NUM_LEDS (NUM_LEDS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .req_op   (req_op),
      .rsp_data (rsp_data)
   );

endmodule

/* test/fru_led_blink_controller_tb.sv */
// ----------------------------------------------------------------------------
// fru_led_blink_controller_tb
// Self-checking bench for the front-panel LED controller. A cycle-free
// predictor tracks every LED record. It computes the reply that each accepted
// request must produce, and a checker compares each reply strobe with the
// oldest prediction. Stimulus runs a short directed pass, then one long
// blink phase, then random blink sequences and random requests.
// ----------------------------------------------------------------------------
module fru_led_blink_controller_tb;

   localparam int NUM_LEDS    = fru_led_pkg::NUM_LEDS_DEFAULT;
   localparam int STALL_LIMIT = 2000;  // cycles without any transfer or reply
   localparam int REPORT_MAX  = 10;
   localparam int DRAIN_WAIT  = 8;     // idle margin after the last reply

   // function codes as plain integers for the request builders
   localparam int FN_OFF_CODE     = int'(fru_led_pkg::FN_OFF);
   localparam int FN_BLINK_CODE   = int'(fru_led_pkg::FN_BLINK_MAX);
   localparam int FN_RESTORE_CODE = int'(fru_led_pkg::FN_RESTORE);
   localparam int FN_ON_CODE      = int'(fru_led_pkg::FN_ON);

   logic                 clock    = 1'b0;
   logic                 reset    = 1'b1;
   logic                 start    = 1'b0;
   logic                 busy;
   fru_led_pkg::req_type req_data = '0;
   logic                 rsp_strobe;
   fru_led_pkg::rsp_type rsp_data;

   // Predicted LED records, one entry per LED.
   logic       led_lit      [NUM_LEDS];
   logic       led_override [NUM_LEDS];
   logic       led_blink_on [NUM_LEDS];  // level last driven under override
   logic       led_local    [NUM_LEDS];
   logic [7:0] led_count    [NUM_LEDS];
   logic [7:0] led_off_time [NUM_LEDS];
   logic [7:0] led_on_time  [NUM_LEDS];

   fru_led_pkg::rsp_type expected_replies [$];
   int                   mismatch_count = 0;
   int                   stall_cycles   = 0;
   bit                   burst_mode     = 1'b0;  // suppress sender gaps while set

   fru_led_blink_controller #(.NUM_LEDS(NUM_LEDS)) uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Predictor: apply one request to the LED records and return its reply.
   // -------------------------------------------------------------------------
   function automatic fru_led_pkg::rsp_type predict_reply(fru_led_pkg::req_type r);
      fru_led_pkg::rsp_type rsp;
      int                   n;
      logic [7:0]           fn;
      rsp = '0;
      n   = int'(r.led_id);
      fn  = r.led_function;
      if (r.op == fru_led_pkg::OP_TICK) begin
         // Step every overridden LED; led_id only selects the reply fields.
         for (int i = 0; i < NUM_LEDS; i++) begin
            if (!led_override[i]) begin
               continue;
            end
            if (led_off_time[i] == fru_led_pkg::FN_OFF ||
                led_off_time[i] == fru_led_pkg::FN_ON) begin
               // Steady override: post-decrement, drive once the count was zero.
               if (led_count[i] == 8'd0) begin
                  led_lit[i]      = (led_off_time[i] == fru_led_pkg::FN_ON);
                  led_blink_on[i] = (led_off_time[i] == fru_led_pkg::FN_ON);
               end
               led_count[i] = led_count[i] - 8'd1;
            end else begin
               led_count[i] = led_count[i] - 8'd1;
               if (led_count[i] == 8'd0) begin
                  // Toggle and reload with the length of the new phase.
                  if (!led_blink_on[i]) begin
                     led_count[i]    = led_on_time[i];
                     led_lit[i]      = 1'b1;
                     led_blink_on[i] = 1'b1;
                  end else begin
                     led_count[i]    = led_off_time[i];
                     led_lit[i]      = 1'b0;
                     led_blink_on[i] = 1'b0;
                  end
               end
            end
         end
      end else if (n >= NUM_LEDS) begin
         rsp.status = fru_led_pkg::STATUS_BAD_LED;
      end else if (r.op == fru_led_pkg::OP_SET) begin
         if (fn != fru_led_pkg::FN_OFF && fn <= fru_led_pkg::FN_BLINK_MAX) begin
            // Enter blink: invert at once and load the new phase length.
            led_off_time[n] = fn;
            led_on_time[n]  = r.on_time;
            led_override[n] = 1'b1;
            if (led_blink_on[n]) begin
               led_lit[n]      = 1'b0;
               led_blink_on[n] = 1'b0;
               led_count[n]    = fn;
            end else begin
               led_lit[n]      = 1'b1;
               led_blink_on[n] = 1'b1;
               led_count[n]    = r.on_time;
            end
         end else if (fn == fru_led_pkg::FN_OFF || fn == fru_led_pkg::FN_ON) begin
            // Leave override without touching the pin.
            led_off_time[n] = fn;
            led_on_time[n]  = 8'd0;
            led_override[n] = 1'b0;
         end else if (fn == fru_led_pkg::FN_RESTORE) begin
            led_override[n] = 1'b0;
            led_lit[n]      = led_local[n];
         end else begin
            rsp.status = fru_led_pkg::STATUS_BAD_FN;
         end
      end else if (r.op == fru_led_pkg::OP_LOCAL && !led_override[n]) begin
         led_local[n] = r.local_on;
         led_lit[n]   = r.local_on;
      end
      if (n < NUM_LEDS) begin
         rsp.override_active   = led_override[n];
         rsp.local_value       = led_local[n];
         rsp.override_function = led_off_time[n];
         rsp.override_on_time  = led_on_time[n];
      end
      for (int i = 0; i < NUM_LEDS && i < fru_led_pkg::MASK_W; i++) begin
         rsp.lit_mask[i] = led_lit[i];
      end
      return rsp;
   endfunction

   // -------------------------------------------------------------------------
   // Request builders.
   // -------------------------------------------------------------------------
   function automatic fru_led_pkg::req_type build_req(logic [1:0] op, int id, int fn,
                                                      int on_ticks, int loc);
      fru_led_pkg::req_type r;
      r.op           = op;
      r.led_id       = fru_led_pkg::LED_ID_W'(id);
      r.led_function = 8'(fn);
      r.on_time      = 8'(on_ticks);
      r.local_on     = 1'(loc);
      return r;
   endfunction

   // Fill the fields that the operation does not use with noise.
   function automatic fru_led_pkg::req_type scatter_req(logic [1:0] op, int id);
      return build_req(op, id, $urandom_range(0, 255), $urandom_range(0, 255),
                       $urandom_range(0, 1));
   endfunction

   // Function codes at and around every boundary of the decode.
   function automatic int special_function();
      case ($urandom_range(0, 7))
         0: return FN_OFF_CODE;
         1: return 1;
         2: return FN_BLINK_CODE;
         3: return FN_BLINK_CODE + 1;
         4: return FN_RESTORE_CODE;
         5: return FN_RESTORE_CODE + 1;
         6: return FN_RESTORE_CODE + 2;
         default: return FN_ON_CODE;
      endcase
   endfunction

   // Phase length: mostly short so that toggles happen often, now and then
   // long, and for the on phase sometimes zero (wraps to 256 ticks).
   function automatic int blink_length(bit on_phase);
      int pick;
      pick = $urandom_range(0, 19);
      if (pick < 15) begin
         return $urandom_range(1, 4);
      end else if (pick < 19) begin
         return on_phase ? $urandom_range(5, 255) : $urandom_range(5, FN_BLINK_CODE);
      end
      return on_phase ? 0 : FN_BLINK_CODE;
   endfunction

   // -------------------------------------------------------------------------
   // Send one request: idle for a random gap, raise start, hold until the
   // transfer, then record its prediction. start stays high on return so
   // back-to-back requests keep it asserted without a glitch.
   // -------------------------------------------------------------------------
   task automatic send_req(input fru_led_pkg::req_type item);
      int gap;
      int pick;
      gap = 0;
      if (!burst_mode) begin
         pick = $urandom_range(0, 99);
         if (pick >= 92) begin
            gap = $urandom_range(6, 40);
         end else if (pick >= 55) begin
            gap = $urandom_range(1, 3);
         end
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
      expected_replies.push_back(predict_reply(item));
   endtask

   // -------------------------------------------------------------------------
   // Tests.
   // -------------------------------------------------------------------------

   // Reset state, rejected indexes, every function boundary and the
   // override/local interactions.
   task automatic test_directed();
      send_req(build_req(fru_led_pkg::OP_READ, 0, 0, 0, 0));        // LED 0 after reset
      send_req(build_req(fru_led_pkg::OP_READ, 7, 255, 255, 1));    // index out of range
      send_req(build_req(fru_led_pkg::OP_SET, NUM_LEDS, 1, 1, 0));  // set on a missing LED
      send_req(build_req(fru_led_pkg::OP_LOCAL, 5, 0, 0, 1));       // local on a missing LED
      send_req(build_req(fru_led_pkg::OP_TICK, 6, 0, 0, 0));        // tick ignores led_id
      send_req(build_req(fru_led_pkg::OP_SET, 1, 1, 255, 0));       // shortest off, long on
      send_req(build_req(fru_led_pkg::OP_TICK, 1, 0, 0, 0));
      send_req(build_req(fru_led_pkg::OP_SET, 2, FN_BLINK_CODE, 0, 0));  // wrapping on
      send_req(build_req(fru_led_pkg::OP_LOCAL, 2, 0, 0, 1));       // ignored under override
      send_req(build_req(fru_led_pkg::OP_SET, 1, FN_BLINK_CODE + 1, 3, 0));    // unsupported
      send_req(build_req(fru_led_pkg::OP_SET, 1, FN_RESTORE_CODE + 1, 3, 0));  // unsupported
      send_req(build_req(fru_led_pkg::OP_SET, 1, FN_RESTORE_CODE + 2, 3, 0));  // unsupported
      send_req(build_req(fru_led_pkg::OP_SET, 1, FN_OFF_CODE, 77, 0));  // leave, pin kept
      send_req(build_req(fru_led_pkg::OP_READ, 1, 0, 0, 0));
      send_req(build_req(fru_led_pkg::OP_SET, 2, FN_ON_CODE, 200, 0));  // leave, pin kept
      send_req(build_req(fru_led_pkg::OP_SET, 2, FN_RESTORE_CODE, 0, 0));  // back to local
      send_req(build_req(fru_led_pkg::OP_LOCAL, 1, 0, 0, 1));
      send_req(build_req(fru_led_pkg::OP_LOCAL, 1, 0, 0, 0));
      send_req(build_req(fru_led_pkg::OP_SET, 0, FN_RESTORE_CODE, 0, 0));
      send_req(build_req(fru_led_pkg::OP_LOCAL, 0, 0, 0, 0));
      send_req(build_req(fru_led_pkg::OP_READ, 0, 255, 255, 1));
      send_req(build_req(fru_led_pkg::OP_TICK, 0, 255, 255, 1));
   endtask

   // One LED with an off time of one tick and an on time of zero, held long
   // enough for the countdown to wrap all the way round.
   task automatic test_long_phase();
      int led;
      led = $urandom_range(0, NUM_LEDS - 1);
      send_req(build_req(fru_led_pkg::OP_SET, led, 1, 0, 0));
      for (int i = 0; i < 262; i++) begin
         burst_mode = (i % 64) < 24;
         send_req(scatter_req(fru_led_pkg::OP_TICK, $urandom_range(0, 7)));
      end
      burst_mode = 1'b0;
      send_req(build_req(fru_led_pkg::OP_SET, led, FN_RESTORE_CODE, 0, 0));
   endtask

   // Blink sequences: enter blink, tick it through several toggles with reads,
   // local drives and other requests mixed in, then often leave override.
   task automatic test_blink_sequences();
      int led;
      int pick;
      for (int s = 0; s < 30; s++) begin
         burst_mode = ($urandom_range(0, 3) == 0);
         led = ($urandom_range(0, 9) == 0) ? $urandom_range(NUM_LEDS, 7)
                                           : $urandom_range(0, NUM_LEDS - 1);
         send_req(build_req(fru_led_pkg::OP_SET, led, blink_length(1'b0),
                            blink_length(1'b1), $urandom_range(0, 1)));
         repeat ($urandom_range(6, 18)) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
               send_req(scatter_req(fru_led_pkg::OP_TICK, $urandom_range(0, 7)));
            end else if (pick < 75) begin
               send_req(scatter_req(fru_led_pkg::OP_READ, $urandom_range(0, NUM_LEDS)));
            end else if (pick < 85) begin
               send_req(scatter_req(fru_led_pkg::OP_LOCAL, led));
            end else if (pick < 93) begin
               send_req(build_req(fru_led_pkg::OP_SET, $urandom_range(0, NUM_LEDS - 1),
                                  blink_length(1'b0), blink_length(1'b1),
                                  $urandom_range(0, 1)));
            end else begin
               send_req(scatter_req(2'($urandom_range(0, 3)), $urandom_range(0, 7)));
            end
         end
         // Close the sequence in one of the ways that leave override, or not.
         case ($urandom_range(0, 5))
            0: send_req(build_req(fru_led_pkg::OP_SET, led, FN_RESTORE_CODE,
                                  $urandom_range(0, 255), 0));
            1: send_req(build_req(fru_led_pkg::OP_SET, led, FN_OFF_CODE,
                                  $urandom_range(0, 255), 0));
            2: send_req(build_req(fru_led_pkg::OP_SET, led, FN_ON_CODE,
                                  $urandom_range(0, 255), 0));
            3: send_req(build_req(fru_led_pkg::OP_SET, led, special_function(), 0, 0));
            default: ;
         endcase
         if ($urandom_range(0, 1)) begin
            send_req(scatter_req(fru_led_pkg::OP_LOCAL, led));
         end
      end
      burst_mode = 1'b0;
   endtask

   // Unstructured requests, half of them with boundary function codes.
   task automatic test_random_mix();
      int fn;
      repeat (120) begin
         burst_mode = ($urandom_range(0, 9) == 0);
         fn = $urandom_range(0, 1) ? special_function() : $urandom_range(0, 255);
         send_req(build_req(2'($urandom_range(0, 3)), $urandom_range(0, 7), fn,
                            $urandom_range(0, 255), $urandom_range(0, 1)));
      end
      burst_mode = 1'b0;
   endtask

   // -------------------------------------------------------------------------
   // Reply checker: every strobe must match the oldest prediction.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      fru_led_pkg::rsp_type want;
      if (!reset && rsp_strobe) begin
         if (expected_replies.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX) begin
               $display("unexpected reply: %p", rsp_data);
            end
         end else begin
            want = expected_replies.pop_front();
            if (rsp_data.status !== want.status ||
                rsp_data.override_active !== want.override_active ||
                rsp_data.local_value !== want.local_value ||
                rsp_data.override_function !== want.override_function ||
                rsp_data.override_on_time !== want.override_on_time ||
                rsp_data.lit_mask !== want.lit_mask) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX) begin
                  $display("reply mismatch: expected %p", want);
                  $display("                actual   %p", rsp_data);
               end
            end
         end
      end
   end

   // Watchdog: drop the run when nothing moves for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Main sequence.
   // -------------------------------------------------------------------------
   initial begin
      // Predictor comes out of reset like the block: LED 0 lit and local high.
      for (int i = 0; i < NUM_LEDS; i++) begin
         led_lit[i]      = 1'b0;
         led_override[i] = 1'b0;
         led_blink_on[i] = 1'b0;
         led_local[i]    = 1'b0;
         led_count[i]    = 8'd0;
         led_off_time[i] = 8'd0;
         led_on_time[i]  = 8'd0;
      end
      led_lit[0]      = 1'b1;
      led_local[0]    = 1'b1;
      led_off_time[0] = fru_led_pkg::FN_ON;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_long_phase();
      test_blink_sequences();
      test_random_mix();

      // Drop start and drain the outstanding replies.
      start <= 1'b0;
      while (expected_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
